// ===== rtl/bba_pkg.sv =====
// shared types, constants and map-layout functions for the buddy block allocator
// no dependencies; every other rtl file refers to this package by scoped names
package bba_pkg;

    localparam int POOL_BYTES = 1024;
    localparam int LVL_W      = 3;
    localparam int ADDR_W     = 10;
    localparam int CNT_W      = 11;
    localparam int IDX_W      = 9;
    localparam int ROW_W      = 32;
    localparam int BIT_W      = 5;
    localparam int PAR_W      = ROW_W / 2;
    localparam int MAP_ROWS   = 34;
    localparam int ROW_AW     = 6;

    localparam logic [LVL_W-1:0]  TOP_LEVEL  = 3'd7;
    localparam logic [LVL_W-1:0]  MERGE_TOP  = 3'd6;
    localparam logic [ROW_AW-1:0] TOP_ROW    = 6'd33;
    localparam logic [ROW_W-1:0]  TOP_INIT   = 32'h0000_000F;
    localparam logic [CNT_W-1:0]  POOL_COUNT = 11'd1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // row unit operations
    localparam logic [1:0] ROW_SET   = 2'd0;
    localparam logic [1:0] ROW_CLR   = 2'd1;
    localparam logic [1:0] ROW_MERGE = 2'd2;
    localparam logic [1:0] ROW_PASS  = 2'd3;

    typedef struct packed {
        logic              command;
        logic [LVL_W-1:0]  size_class;
        logic [ADDR_W-1:0] block_address;
    } t_in_word;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  free_bytes;
    } t_out_word;

    typedef struct packed {
        logic              wr_en;
        logic [ROW_AW-1:0] wr_addr;
        logic [ROW_W-1:0]  wr_data;
        logic              rd_en;
        logic [ROW_AW-1:0] rd_addr;
    } t_map_req;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [PAR_W-1:0]  parent;
        logic              any_pair;
        logic [ROW_AW-1:0] loc_row;
        logic [BIT_W-1:0]  loc_bit;
    } t_row_res;

    // first map row of each level; levels 0..4 take 16,8,4,2,1 rows, 5..7 one row each
    function automatic logic [ROW_AW-1:0] row_base(input logic [LVL_W-1:0] lv);
        logic [ROW_AW-1:0] b;
        unique case (lv)
            3'd0: b = 6'd0;
            3'd1: b = 6'd16;
            3'd2: b = 6'd24;
            3'd3: b = 6'd28;
            3'd4: b = 6'd30;
            3'd5: b = 6'd31;
            3'd6: b = 6'd32;
            3'd7: b = 6'd33;
            default: b = 6'd0;
        endcase
        return b;
    endfunction

    function automatic logic [BIT_W-1:0] level_rows(input logic [LVL_W-1:0] lv);
        logic [BIT_W-1:0] n;
        unique case (lv)
            3'd0: n = 5'd16;
            3'd1: n = 5'd8;
            3'd2: n = 5'd4;
            3'd3: n = 5'd2;
            default: n = 5'd1;
        endcase
        return n;
    endfunction

    function automatic logic [LVL_W-1:0] row_level(input logic [ROW_AW-1:0] r);
        logic [LVL_W-1:0] lv;
        priority if (r >= 6'd33) lv = 3'd7;
        else if (r >= 6'd32)     lv = 3'd6;
        else if (r >= 6'd31)     lv = 3'd5;
        else if (r >= 6'd30)     lv = 3'd4;
        else if (r >= 6'd28)     lv = 3'd3;
        else if (r >= 6'd24)     lv = 3'd2;
        else if (r >= 6'd16)     lv = 3'd1;
        else                     lv = 3'd0;
        return lv;
    endfunction

endpackage

// ===== rtl/bba_map_store.sv =====
// free map storage: 34 rows of 32 bits, a per-row nonzero flag and the reset clearing pass
// depends on bba_pkg
module bba_map_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bba_pkg::t_map_req             i_req,
    output logic [bba_pkg::ROW_W-1:0]     o_rd_data,
    output logic [bba_pkg::MAP_ROWS-1:0]  o_summary,
    output logic                          o_ready
);

    logic [bba_pkg::ROW_W-1:0]    r_mem [bba_pkg::MAP_ROWS];
    logic [bba_pkg::ROW_W-1:0]    r_rd_data;
    logic [bba_pkg::MAP_ROWS-1:0] r_summary;
    logic                         r_clr_busy;
    logic [bba_pkg::ROW_AW-1:0]   r_clr_row;

    logic                       w_wr_en;
    logic [bba_pkg::ROW_AW-1:0] w_wr_addr;
    logic [bba_pkg::ROW_W-1:0]  w_wr_data;

    // clearing pass owns the write port until every row is initialized
    always_comb begin
        w_wr_en   = r_clr_busy | i_req.wr_en;
        w_wr_addr = r_clr_busy ? r_clr_row : i_req.wr_addr;
        if (r_clr_busy) begin
            w_wr_data = (r_clr_row == bba_pkg::TOP_ROW) ? bba_pkg::TOP_INIT : '0;
        end else begin
            w_wr_data = i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
            r_summary  <= '0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_row == bba_pkg::ROW_AW'(bba_pkg::MAP_ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (w_wr_en) begin
                r_summary[w_wr_addr] <= |w_wr_data;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_summary = r_summary;
    assign o_ready   = !r_clr_busy;

endmodule

// ===== rtl/bba_row_unit.sv =====
// shared row unit: locates a block bit in the map and sets, clears or merges within one row
// depends on bba_pkg
module bba_row_unit (
    input  logic [1:0]                 i_op,
    input  logic [bba_pkg::ROW_W-1:0]  i_row,
    input  logic [bba_pkg::BIT_W-1:0]  i_bit,
    input  logic [bba_pkg::LVL_W-1:0]  i_level,
    input  logic [bba_pkg::IDX_W-1:0]  i_index,
    output bba_pkg::t_row_res          o_res
);

    logic [bba_pkg::ROW_W-1:0] w_merged;
    logic [bba_pkg::PAR_W-1:0] w_pairs;

    always_comb begin
        w_merged = i_row;
        for (int m = 0; m < bba_pkg::PAR_W; m++) begin
            w_pairs[m] = i_row[2*m] & i_row[2*m+1];
            if (w_pairs[m]) begin
                w_merged[2*m]   = 1'b0;
                w_merged[2*m+1] = 1'b0;
            end
        end
    end

    always_comb begin
        o_res.parent   = w_pairs;
        o_res.any_pair = |w_pairs;
        // every level's bit index splits into row offset and bit within the row
        o_res.loc_row  = bba_pkg::row_base(i_level)
                       + bba_pkg::ROW_AW'(i_index[bba_pkg::IDX_W-1:bba_pkg::BIT_W]);
        o_res.loc_bit  = i_index[bba_pkg::BIT_W-1:0];
        unique case (i_op)
            bba_pkg::ROW_SET:   o_res.row = i_row | (bba_pkg::ROW_W'(1) << i_bit);
            // lowest free block is the one taken
            bba_pkg::ROW_CLR:   o_res.row = i_row & (i_row - 1'b1);
            bba_pkg::ROW_MERGE: o_res.row = w_merged;
            default:            o_res.row = i_row;
        endcase
    end

endmodule

// ===== rtl/buddy_block_allocator_unit.sv =====
// allocate: a search, a read and a write of the hit row, then a read and a write per split level;
// a failed allocate goes from the search to the result. free: a read and a write of the block's
//   row, then a scan of map rows for levels k..6 that skips empty rows and merges buddy pairs
// one word at a time through a row store with one read and one write port and the shared row unit
// reset: synchronous, active low; a clearing pass over every map row then leaves four 256-byte blocks free
// results sit in an output register; a new word is taken while the last result waits
module buddy_block_allocator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bba_pkg::t_in_word     i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bba_pkg::t_out_word    o_out_word
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ASRCH = 4'd1;
    localparam logic [3:0] S_AFIND = 4'd2;
    localparam logic [3:0] S_SRD   = 4'd3;
    localparam logic [3:0] S_SWR   = 4'd4;
    localparam logic [3:0] S_FSET  = 4'd5;
    localparam logic [3:0] S_FWR   = 4'd6;
    localparam logic [3:0] S_MRD   = 4'd7;
    localparam logic [3:0] S_MCHK  = 4'd8;
    localparam logic [3:0] S_MPAR  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]                   r_state,  n_state;
    logic [bba_pkg::LVL_W-1:0]    r_k,      n_k;
    logic [bba_pkg::ADDR_W-1:0]   r_addr,   n_addr;
    logic [bba_pkg::LVL_W-1:0]    r_lv,     n_lv;
    logic [3:0]                   r_q,      n_q;
    logic [bba_pkg::ROW_AW-1:0]   r_row,    n_row;
    logic [bba_pkg::BIT_W-1:0]    r_bit,    n_bit;
    logic [bba_pkg::ADDR_W-1:0]   r_base,   n_base;
    logic                         r_half,   n_half;
    logic [bba_pkg::PAR_W-1:0]    r_par,    n_par;
    logic [bba_pkg::CNT_W-1:0]    r_cnt,    n_cnt;
    logic                         r_status, n_status;
    logic                         r_out_valid, n_out_valid;
    bba_pkg::t_out_word           r_out_word,  n_out_word;

    bba_pkg::t_map_req              w_req;
    logic [bba_pkg::ROW_W-1:0]      w_rd_data;
    logic [bba_pkg::MAP_ROWS-1:0]   w_summary;
    logic                           w_store_ready;
    logic [1:0]                     w_op;
    logic [bba_pkg::LVL_W-1:0]      w_loc_level;
    logic [bba_pkg::IDX_W-1:0]      w_loc_index;
    bba_pkg::t_row_res              w_res;

    logic                           w_accept;
    logic                           w_found;
    logic [bba_pkg::ROW_AW-1:0]     w_hit;
    logic [bba_pkg::ROW_AW-1:0]     w_start;
    logic [bba_pkg::ADDR_W-1:0]     w_split_sh;
    logic [bba_pkg::ADDR_W-1:0]     w_free_sh;
    logic [bba_pkg::ROW_AW-1:0]     w_qdiff;
    logic [bba_pkg::CNT_W-1:0]      w_bytes;
    logic [bba_pkg::CNT_W:0]        w_sum;
    logic [bba_pkg::ROW_AW-1:0]     w_mrow;
    logic                           w_last_row;
    logic                           w_last_lv;
    logic                           w_advance;

    bba_map_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd_data),
        .o_summary (w_summary),
        .o_ready   (w_store_ready)
    );

    bba_row_unit u_row (
        .i_op    (w_op),
        .i_row   (w_rd_data),
        .i_bit   (r_bit),
        .i_level (w_loc_level),
        .i_index (w_loc_index),
        .o_res   (w_res)
    );

    assign o_in_stall = !((r_state == S_IDLE) && w_store_ready);
    assign w_accept   = i_in_valid && !o_in_stall;

    // datapath terms shared by several states
    always_comb begin
        w_start = bba_pkg::row_base(r_k);
        w_found = 1'b0;
        w_hit   = '0;
        // lowest nonzero row at or above the class; rows are in level order
        for (int i = bba_pkg::MAP_ROWS - 1; i >= 0; i--) begin
            if (w_summary[i] && (bba_pkg::ROW_AW'(i) >= w_start)) begin
                w_found = 1'b1;
                w_hit   = bba_pkg::ROW_AW'(i);
            end
        end
        w_split_sh  = r_base >> ({1'b0, r_lv} + 4'd1);
        w_free_sh   = r_addr >> ({1'b0, r_k} + 4'd1);
        w_qdiff     = r_row - bba_pkg::row_base(r_lv);
        w_bytes     = bba_pkg::CNT_W'(2) << r_k;
        w_sum       = {1'b0, r_cnt} + {1'b0, w_bytes};
        w_mrow      = bba_pkg::row_base(r_lv) + {2'b00, r_q};
        w_last_row  = ({1'b0, r_q} == (bba_pkg::level_rows(r_lv) - 5'd1));
        w_last_lv   = (r_lv == bba_pkg::MERGE_TOP);
    end

    // row unit operand selection
    always_comb begin
        w_op        = bba_pkg::ROW_PASS;
        w_loc_level = r_lv;
        w_loc_index = w_split_sh[bba_pkg::IDX_W-1:0] + 1'b1;
        unique case (r_state)
            S_AFIND:      w_op = bba_pkg::ROW_CLR;
            S_SWR, S_FWR: w_op = bba_pkg::ROW_SET;
            S_MCHK:       w_op = bba_pkg::ROW_MERGE;
            S_FSET: begin
                w_loc_level = r_k;
                w_loc_index = w_free_sh[bba_pkg::IDX_W-1:0];
            end
            default: begin
                w_op = bba_pkg::ROW_PASS;
            end
        endcase
    end

    logic [bba_pkg::BIT_W-1:0] w_low_bit;

    // lowest set bit of the row just read
    always_comb begin
        w_low_bit = '0;
        for (int b = bba_pkg::ROW_W - 1; b >= 0; b--) begin
            if (w_rd_data[b]) begin
                w_low_bit = bba_pkg::BIT_W'(b);
            end
        end
    end

    logic [bba_pkg::ADDR_W-1:0] w_alloc_base;
    logic [bba_pkg::IDX_W-1:0]  w_alloc_idx;

    always_comb begin
        w_alloc_idx  = {w_qdiff[3:0], w_low_bit};
        w_alloc_base = {1'b0, w_alloc_idx} << ({1'b0, r_lv} + 4'd1);
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_addr      = r_addr;
        n_lv        = r_lv;
        n_q         = r_q;
        n_row       = r_row;
        n_bit       = r_bit;
        n_base      = r_base;
        n_half      = r_half;
        n_par       = r_par;
        n_cnt       = r_cnt;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        w_req       = '0;
        w_advance   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_k      = i_in_word.size_class;
                    n_addr   = i_in_word.block_address;
                    n_base   = '0;
                    n_status = bba_pkg::STATUS_OK;
                    n_state  = (i_in_word.command == bba_pkg::CMD_FREE) ? S_FSET : S_ASRCH;
                end
            end
            S_ASRCH: begin
                if (!w_found) begin
                    n_status = bba_pkg::STATUS_FAIL;
                    n_state  = S_DONE;
                end else begin
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = w_hit;
                    n_row         = w_hit;
                    n_lv          = bba_pkg::row_level(w_hit);
                    n_state       = S_AFIND;
                end
            end
            S_AFIND: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_row;
                w_req.wr_data = w_res.row;
                n_base        = w_alloc_base;
                n_cnt         = (r_cnt >= w_bytes) ? (r_cnt - w_bytes) : '0;
                if (r_lv == r_k) begin
                    n_state = S_DONE;
                end else begin
                    n_lv    = r_lv - 1'b1;
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                // upper half of the block being split at this level
                w_req.rd_en   = 1'b1;
                w_req.rd_addr = w_res.loc_row;
                n_row         = w_res.loc_row;
                n_bit         = w_res.loc_bit;
                n_state       = S_SWR;
            end
            S_SWR: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_row;
                w_req.wr_data = w_res.row;
                if (r_lv == r_k) begin
                    n_state = S_DONE;
                end else begin
                    n_lv    = r_lv - 1'b1;
                    n_state = S_SRD;
                end
            end
            S_FSET: begin
                w_req.rd_en   = 1'b1;
                w_req.rd_addr = w_res.loc_row;
                n_row         = w_res.loc_row;
                n_bit         = w_res.loc_bit;
                n_cnt         = (w_sum > {1'b0, bba_pkg::POOL_COUNT}) ? bba_pkg::POOL_COUNT
                                                                      : w_sum[bba_pkg::CNT_W-1:0];
                n_state       = S_FWR;
            end
            S_FWR: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_row;
                w_req.wr_data = w_res.row;
                n_lv          = r_k;
                n_q           = '0;
                n_state       = (r_k == bba_pkg::TOP_LEVEL) ? S_DONE : S_MRD;
            end
            S_MRD, S_MCHK, S_MPAR: begin
                w_advance = 1'b1;
                if (r_state == S_MRD) begin
                    // rows with nothing free cannot hold a buddy pair
                    if (w_summary[w_mrow]) begin
                        w_advance     = 1'b0;
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = w_mrow;
                        n_row         = w_mrow;
                        n_state       = S_MCHK;
                    end
                end else if (r_state == S_MCHK) begin
                    if (w_res.any_pair) begin
                        w_advance     = 1'b0;
                        w_req.wr_en   = 1'b1;
                        w_req.wr_addr = r_row;
                        w_req.wr_data = w_res.row;
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = bba_pkg::row_base(r_lv + 1'b1)
                                      + {3'b000, r_q[3:1]};
                        n_row         = w_req.rd_addr;
                        n_half        = r_q[0];
                        n_par         = w_res.parent;
                        n_state       = S_MPAR;
                    end
                end else begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_addr = r_row;
                    w_req.wr_data = w_rd_data | (r_half ? {r_par, {bba_pkg::PAR_W{1'b0}}}
                                                        : {{bba_pkg::PAR_W{1'b0}}, r_par});
                end
                if (w_advance) begin
                    if (w_last_row) begin
                        if (w_last_lv) begin
                            n_state = S_DONE;
                        end else begin
                            n_lv    = r_lv + 1'b1;
                            n_q     = '0;
                            n_state = S_MRD;
                        end
                    end else begin
                        n_q     = r_q + 1'b1;
                        n_state = S_MRD;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid                = 1'b1;
                    n_out_word.status          = r_status;
                    n_out_word.granted_address = r_base;
                    n_out_word.free_bytes      = r_cnt;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= bba_pkg::POOL_COUNT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_addr     <= n_addr;
        r_lv       <= n_lv;
        r_q        <= n_q;
        r_row      <= n_row;
        r_bit      <= n_bit;
        r_base     <= n_base;
        r_half     <= n_half;
        r_par      <= n_par;
        r_status   <= n_status;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while a word is in progress");

    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_store_ready |-> !w_req.wr_en)
        else $error("sequencer wrote the map during the clearing pass");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= bba_pkg::POOL_COUNT)
        else $error("free byte count above pool size");

    a_grant_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |->
            ((r_base & ((bba_pkg::ADDR_W'(2) << r_k) - 1'b1)) == '0))
        else $error("granted address not aligned to its class");

    a_merge_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRD) |-> (r_lv != bba_pkg::TOP_LEVEL))
        else $error("merge scan reached the top level");

endmodule

// ===== tb/buddy_block_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for buddy_block_allocator_unit: directed and random allocate/free words
// are scored against an in-bench model of the free map; needs bba_pkg and the allocator rtl
module buddy_block_allocator_unit_test;

    localparam int CLASSES          = 8;
    localparam int MAP_BITS         = 1020;
    localparam int RESET_CYCLES     = 10;
    localparam int RANDOM_PER_PHASE = 510;
    localparam int TAIL_CYCLES      = 150;
    localparam int QUIET_LIMIT      = 4000;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [bba_pkg::CNT_W-1:0] bytes_free;
        logic [MAP_BITS-1:0]       map;
    } t_pool;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    bba_pkg::t_in_word  in_word = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    bba_pkg::t_out_word out_word;

    bba_pkg::t_in_word  request_queue[$];
    bba_pkg::t_in_word  held_blocks[$];
    bba_pkg::t_out_word expected_replies[$];
    t_pool              model_pool;
    t_pool              plan_pool;

    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles = 0;
    int errors = 0;
    int replies_seen = 0;
    int allocs = 0;
    int refused = 0;
    int frees = 0;

    buddy_block_allocator_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // class lv starts at this map bit and holds this many blocks
    function automatic int level_first(input int lv);
        return bba_pkg::POOL_BYTES - (bba_pkg::POOL_BYTES >> lv);
    endfunction

    function automatic int level_blocks(input int lv);
        return bba_pkg::POOL_BYTES >> (lv + 1);
    endfunction

    function automatic t_pool fresh_pool();
        t_pool p;
        int    i;
        p.bytes_free = bba_pkg::POOL_COUNT;
        p.map = '0;
        for (i = 0; i < level_blocks(int'(bba_pkg::TOP_LEVEL)); i++)
            p.map[level_first(int'(bba_pkg::TOP_LEVEL)) + i] = 1'b1;
        return p;
    endfunction

    function automatic bba_pkg::t_out_word allocator_step(inout t_pool pool,
                                                          input bba_pkg::t_in_word w);
        bba_pkg::t_out_word reply;
        int                 cls, blk, lv, idx, hit_lv, hit_idx, addr, total, b;
        bit                 hit;
        reply = '0;
        reply.status = bba_pkg::STATUS_OK;
        cls = int'(w.size_class);
        blk = 2 << cls;
        if (w.command == bba_pkg::CMD_ALLOC) begin
            hit = 1'b0;
            hit_lv = 0;
            hit_idx = 0;
            for (lv = cls; lv < CLASSES && !hit; lv++) begin
                for (idx = 0; idx < level_blocks(lv) && !hit; idx++) begin
                    if (pool.map[level_first(lv) + idx]) begin
                        hit = 1'b1;
                        hit_lv = lv;
                        hit_idx = idx;
                    end
                end
            end
            if (!hit) begin
                reply.status = bba_pkg::STATUS_FAIL;
            end else begin
                addr = hit_idx * (2 << hit_lv);
                pool.map[level_first(hit_lv) + hit_idx] = 1'b0;
                // split down, leaving each upper half free
                for (lv = hit_lv - 1; lv >= cls; lv--)
                    pool.map[level_first(lv) + addr / (2 << lv) + 1] = 1'b1;
                reply.granted_address = addr[bba_pkg::ADDR_W-1:0];
                total = int'(pool.bytes_free) - blk;
                pool.bytes_free = (total >= 0) ? total[bba_pkg::CNT_W-1:0] : '0;
            end
        end else begin
            idx = (int'(w.block_address) >> (cls + 1)) % level_blocks(cls);
            pool.map[level_first(cls) + idx] = 1'b1;
            total = int'(pool.bytes_free) + blk;
            pool.bytes_free = (total > bba_pkg::POOL_BYTES) ? bba_pkg::POOL_COUNT
                                                            : total[bba_pkg::CNT_W-1:0];
            // sweep the freed class and each class above it below the top, pairs rising into the next class
            for (lv = cls; lv < CLASSES - 1; lv++) begin
                b = level_first(lv);
                for (idx = 0; idx + 1 < level_blocks(lv); idx += 2) begin
                    if (pool.map[b + idx] && pool.map[b + idx + 1]) begin
                        pool.map[b + idx] = 1'b0;
                        pool.map[b + idx + 1] = 1'b0;
                        pool.map[level_first(lv + 1) + idx / 2] = 1'b1;
                    end
                end
            end
        end
        reply.free_bytes = pool.bytes_free;
        return reply;
    endfunction

    // queue a word and track what the bench itself holds, for well-formed frees
    task automatic plan_word(input logic cmd, input int cls, input int addr);
        bba_pkg::t_in_word  w;
        bba_pkg::t_in_word  hold;
        bba_pkg::t_out_word r;
        w.command = cmd;
        w.size_class = cls[bba_pkg::LVL_W-1:0];
        w.block_address = addr[bba_pkg::ADDR_W-1:0];
        r = allocator_step(plan_pool, w);
        request_queue.push_back(w);
        if (cmd == bba_pkg::CMD_ALLOC && r.status == bba_pkg::STATUS_OK) begin
            hold.command = bba_pkg::CMD_FREE;
            hold.size_class = w.size_class;
            hold.block_address = r.granted_address;
            held_blocks.push_back(hold);
        end
    endtask

    task automatic plan_random(input int n);
        int                k, roll, pick, cls;
        bba_pkg::t_in_word w;
        for (k = 0; k < n; k++) begin
            roll = int'($urandom_range(99));
            if (roll < 6) begin
                // stray free: double, overlapping or unaligned most of the time
                plan_word(bba_pkg::CMD_FREE, int'($urandom_range(7)),
                          int'($urandom_range(1023)));
            end else if (held_blocks.size() != 0 &&
                         roll < ((plan_pool.bytes_free < 256) ? 75 : 45)) begin
                pick = int'($urandom_range(held_blocks.size() - 1));
                w = held_blocks[pick];
                held_blocks.delete(pick);
                plan_word(w.command, int'(w.size_class), int'(w.block_address));
            end else begin
                cls = ($urandom_range(3) != 0) ? int'($urandom_range(4))
                                               : int'($urandom_range(7));
                plan_word(bba_pkg::CMD_ALLOC, cls, int'($urandom_range(1023)));
            end
        end
    endtask

    task automatic wait_for_requests();
        while (request_queue.size() != 0 || in_valid)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk) begin : drive_requests
        bba_pkg::t_out_word predicted;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predicted = allocator_step(model_pool, in_word);
                expected_replies.push_back(predicted);
                if (in_word.command == bba_pkg::CMD_ALLOC) begin
                    allocs++;
                    if (predicted.status == bba_pkg::STATUS_FAIL)
                        refused++;
                end else begin
                    frees++;
                end
            end
            if (!in_valid || !in_stall) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_word <= request_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : check_replies
        bba_pkg::t_out_word want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected reply: status %0d addr %0d free %0d",
                                 $time, out_word.status, out_word.granted_address,
                                 out_word.free_bytes);
                end else begin
                    want = expected_replies.pop_front();
                    if (want.status !== out_word.status ||
                        want.granted_address !== out_word.granted_address ||
                        want.free_bytes !== out_word.free_bytes) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: reply %0d want %0d %0d %0d, got %0d %0d %0d",
                                     $time, replies_seen, want.status, want.granted_address,
                                     want.free_bytes, out_word.status,
                                     out_word.granted_address, out_word.free_bytes);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // no word moving on either side for too long means a hang
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int k;
        model_pool = fresh_pool();
        plan_pool = fresh_pool();
        send_idle_pct = 32;
        recv_idle_pct = 71;

        plan_word(bba_pkg::CMD_ALLOC, 7, 0);
        plan_word(bba_pkg::CMD_ALLOC, 0, 1023);     // address is ignored on allocate
        plan_word(bba_pkg::CMD_FREE, 0, 256);       // merges all the way back to 256 bytes
        for (k = 0; k < 3; k++)
            plan_word(bba_pkg::CMD_ALLOC, 7, 0);    // pool now empty
        plan_word(bba_pkg::CMD_ALLOC, 0, 0);        // refused
        plan_word(bba_pkg::CMD_ALLOC, 7, 0);        // refused
        plan_word(bba_pkg::CMD_FREE, 7, 1023);      // unaligned, truncates to 768
        for (k = 0; k < 3; k++)
            plan_word(bba_pkg::CMD_FREE, 7, k * 256);
        // count saturates high on an overlapping free, then clamps at zero
        plan_word(bba_pkg::CMD_ALLOC, 0, 0);
        plan_word(bba_pkg::CMD_FREE, 7, 0);
        for (k = 0; k < 4; k++)
            plan_word(bba_pkg::CMD_ALLOC, 7, 0);
        plan_word(bba_pkg::CMD_ALLOC, 6, 0);        // stale split halves still in the map
        for (k = 0; k < 4; k++)
            plan_word(bba_pkg::CMD_FREE, 7, k * 256);
        plan_word(bba_pkg::CMD_FREE, 6, 128);
        plan_word(bba_pkg::CMD_FREE, 0, 0);         // rejoins the stale halves
        held_blocks.delete();

        plan_random(RANDOM_PER_PHASE);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        wait_for_requests();

        send_idle_pct = 71;
        recv_idle_pct = 32;
        plan_random(RANDOM_PER_PHASE);
        wait_for_requests();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        plan_random(RANDOM_PER_PHASE);
        wait_for_requests();

        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        errors += expected_replies.size();

        $display("covered %0d allocations (%0d refused) and %0d frees, %0d replies checked",
                 allocs, refused, frees, replies_seen);
        $display("%0d bad or missing replies", errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bba_pkg.sv
rtl/bba_map_store.sv
rtl/bba_row_unit.sv
rtl/buddy_block_allocator_unit.sv
tb/buddy_block_allocator_unit_test.sv
